/* src/dq_pkg.sv */
// ---------------------------------------------------------------------------
// dq_pkg: shared types and codes for the double-ended queue
// Request and status codes, fixed field widths, and the command that goes
// to every storage cell.
// ---------------------------------------------------------------------------
package dq_pkg;

  localparam int REQ_W    = 3;
  localparam int STATUS_W = 2;
  localparam int FIELD_W  = 32;
  localparam int TOTAL_W  = 5;

  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH_FRONT = 3'd0,
    REQ_PUSH_BACK  = 3'd1,
    REQ_POP_FRONT  = 3'd2,
    REQ_POP_BACK   = 3'd3,
    REQ_CLEAR      = 3'd4
  } req_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // one-cycle command broadcast along the cell row
  typedef struct packed {
    logic push_front;   // shift toward the back, cell 0 takes the new word
    logic push_back;    // the cell at the fill point takes the new word
    logic pop_front;    // shift toward the front
  } cell_cmd_t;

endpackage

/* src/dq_cell.sv */
// ---------------------------------------------------------------------------
// dq_cell: one storage cell of the deque row
// Holds one word; takes its neighbor's word on a shift, or the new word when
// it sits at the fill point. Offers its word when it holds the back entry.
// ---------------------------------------------------------------------------
module dq_cell
  import dq_pkg::*;
#(
  parameter int DATA_WIDTH = 32,
  parameter int CNT_W      = 5,
  parameter int IDX        = 0
) (
  input  logic                  clk,
  input  cell_cmd_t             cmd,
  input  logic [CNT_W-1:0]      count,      // entries held now
  input  logic [CNT_W-1:0]      tail,       // slot of the back entry
  input  logic [DATA_WIDTH-1:0] new_word,
  input  logic [DATA_WIDTH-1:0] left_word,  // toward the front
  input  logic [DATA_WIDTH-1:0] right_word, // toward the back
  output logic [DATA_WIDTH-1:0] word,
  output logic [DATA_WIDTH-1:0] tail_word   // own word if back entry, else 0
);

  localparam logic [CNT_W-1:0] IDX_C = CNT_W'(IDX);

  logic [DATA_WIDTH-1:0] word_r;
  logic [DATA_WIDTH-1:0] word_nxt;

  always_comb begin
    word_nxt = word_r;
    if (cmd.push_front) begin
      word_nxt = left_word;
    end else if (cmd.push_back && (count == IDX_C)) begin
      word_nxt = new_word;
    end else if (cmd.pop_front) begin
      word_nxt = right_word;
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign word      = word_r;
  assign tail_word = (tail == IDX_C) ? word_r : '0;

endmodule

/* src/double_ended_queue.sv */
// ---------------------------------------------------------------------------
// double_ended_queue: bounded deque built as a row of shifting cells
// Results: the result word of each accepted request is held in the output register.
// Throughput: one request per cycle while in_stall is low; each request updates
// the entry count and any cells it writes in the same cycle it is accepted.
// Reset: synchronous, active low; entry count and result valid clear, cell
// contents are left as they are (never readable before a push).
// ---------------------------------------------------------------------------
module double_ended_queue
  import dq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16,
  parameter int DATA_WIDTH  = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  // request channel
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [REQ_W-1:0]    in_req_type,
  input  logic [FIELD_W-1:0]  in_item_data,
  // result channel
  output logic                out_valid,
  input  logic                out_stall,
  output logic [FIELD_W-1:0]  out_pop_data,
  output logic                out_pop_valid,
  output logic [STATUS_W-1:0] out_status,
  output logic [TOTAL_W-1:0]  out_entry_total
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);

  // Entries live in cells 0..count-1, cell 0 is the front. Push front and
  // pop front shift the whole row; push back writes the cell at the fill
  // point; pop back reads the cell just below it.

  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [CNT_W-1:0]      tail;
  logic                  accept;
  cell_cmd_t             cmd;
  logic [DATA_WIDTH-1:0] new_word;
  logic [DATA_WIDTH-1:0] cell_word [QUEUE_DEPTH];
  logic [DATA_WIDTH-1:0] cell_tail [QUEUE_DEPTH];
  logic [DATA_WIDTH-1:0] back_word;

  // result word fields
  logic                  out_valid_r;
  logic [FIELD_W-1:0]    pop_data_r, pop_data_nxt;
  logic                  pop_valid_r, pop_valid_nxt;
  status_t               status_r, status_nxt;
  logic [TOTAL_W-1:0]    total_r;

  // output register parts the two sides: a new request is taken whenever
  // the held result leaves or no result is held
  assign in_stall = out_valid_r & out_stall;
  assign accept   = in_valid & ~in_stall;
  assign new_word = DATA_WIDTH'(in_item_data);
  assign tail     = count_r - CNT_W'(1);

  // request decode
  always_comb begin
    cmd           = '0;
    count_nxt     = count_r;
    pop_data_nxt  = '0;
    pop_valid_nxt = 1'b0;
    status_nxt    = ST_OK;
    if (accept) begin
      case (in_req_type)
        REQ_PUSH_FRONT: begin
          if (count_r == DEPTH_C) begin
            status_nxt = ST_FULL;
          end else begin
            cmd.push_front = 1'b1;
            count_nxt      = count_r + CNT_W'(1);
          end
        end
        REQ_PUSH_BACK: begin
          if (count_r == DEPTH_C) begin
            status_nxt = ST_FULL;
          end else begin
            cmd.push_back = 1'b1;
            count_nxt     = count_r + CNT_W'(1);
          end
        end
        REQ_POP_FRONT: begin
          if (count_r == '0) begin
            status_nxt = ST_EMPTY;
          end else begin
            cmd.pop_front = 1'b1;
            pop_data_nxt  = FIELD_W'(cell_word[0]);
            pop_valid_nxt = 1'b1;
            count_nxt     = count_r - CNT_W'(1);
          end
        end
        REQ_POP_BACK: begin
          if (count_r == '0) begin
            status_nxt = ST_EMPTY;
          end else begin
            pop_data_nxt  = FIELD_W'(back_word);
            pop_valid_nxt = 1'b1;
            count_nxt     = count_r - CNT_W'(1);
          end
        end
        REQ_CLEAR: begin
          count_nxt = '0;  // words stay in the cells, now unreachable
        end
        default: begin
          // unused codes: no change, ok status
        end
      endcase
    end
  end

  // the cell row
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_w;
    logic [DATA_WIDTH-1:0] right_w;

    if (i == 0) begin : g_head
      assign left_w = new_word;
    end else begin : g_body
      assign left_w = cell_word[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign right_w = cell_word[i];
    end else begin : g_mid
      assign right_w = cell_word[i+1];
    end

    dq_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .CNT_W      (CNT_W),
      .IDX        (i)
    ) u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .count      (count_r),
      .tail       (tail),
      .new_word   (new_word),
      .left_word  (left_w),
      .right_word (right_w),
      .word       (cell_word[i]),
      .tail_word  (cell_tail[i])
    );
  end

  // only the back cell offers its word; every other cell gives zero
  always_comb begin
    back_word = '0;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      back_word = back_word | cell_tail[i];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload, loaded with each accepted request
  always_ff @(posedge clk) begin
    if (accept) begin
      pop_data_r  <= pop_data_nxt;
      pop_valid_r <= pop_valid_nxt;
      status_r    <= status_nxt;
      total_r     <= TOTAL_W'(count_nxt);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pop_data    = pop_data_r;
  assign out_pop_valid   = pop_valid_r;
  assign out_status      = status_r;
  assign out_entry_total = total_r;

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top: self-checking bench for the double-ended queue
// Drives push, pop, clear and unused request words, predicts every result
// word with a behavioral deque model, and compares the results in order.
// Both channels idle at random, and the result side holds off for a long
// stretch once so that the queue backs up into the request channel.
// ---------------------------------------------------------------------------
module tb_top;
  import dq_pkg::*;

  localparam int DEPTH      = 16;
  localparam int IDLE_LIMIT = 2000;  // cycles with no handshake on either side
  localparam int HOLD_LEN   = 80;    // long result-side hold-off, in cycles

  // result word as the predictor sees it
  typedef struct packed {
    logic [FIELD_W-1:0]  pop_data;
    logic                pop_valid;
    status_t             status;
    logic [TOTAL_W-1:0]  total;
  } dq_result_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [REQ_W-1:0]    in_req_type = '0;
  logic [FIELD_W-1:0]  in_item_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [FIELD_W-1:0]  out_pop_data;
  logic                out_pop_valid;
  logic [STATUS_W-1:0] out_status;
  logic [TOTAL_W-1:0]  out_entry_total;

  double_ended_queue u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_req_type     (in_req_type),
    .in_item_data    (in_item_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_pop_data    (out_pop_data),
    .out_pop_valid   (out_pop_valid),
    .out_status      (out_status),
    .out_entry_total (out_entry_total)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // -------------------------------------------------------------------------
  // Deque predictor: circular store, front slot, slot past the back, count.
  // Refused requests leave all of it untouched.
  // -------------------------------------------------------------------------
  logic [FIELD_W-1:0] slot_word [DEPTH];
  int                 head_slot;
  int                 tail_slot;
  int                 held_count;

  dq_result_t pending_results[$];   // expected result words, oldest first
  int         mismatch_count;

  function automatic dq_result_t apply_request(input logic [REQ_W-1:0] req,
                                               input logic [FIELD_W-1:0] word);
    dq_result_t r;
    r        = '0;
    r.status = ST_OK;
    case (req)
      REQ_PUSH_FRONT: begin
        if (held_count == DEPTH) begin
          r.status = ST_FULL;
        end else begin
          head_slot            = (head_slot == 0) ? DEPTH - 1 : head_slot - 1;
          slot_word[head_slot] = word;
          held_count++;
        end
      end
      REQ_PUSH_BACK: begin
        if (held_count == DEPTH) begin
          r.status = ST_FULL;
        end else begin
          slot_word[tail_slot] = word;
          tail_slot            = (tail_slot == DEPTH - 1) ? 0 : tail_slot + 1;
          held_count++;
        end
      end
      REQ_POP_FRONT: begin
        if (held_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.pop_data  = slot_word[head_slot];
          r.pop_valid = 1'b1;
          head_slot   = (head_slot == DEPTH - 1) ? 0 : head_slot + 1;
          held_count--;
        end
      end
      REQ_POP_BACK: begin
        if (held_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          tail_slot   = (tail_slot == 0) ? DEPTH - 1 : tail_slot - 1;
          r.pop_data  = slot_word[tail_slot];
          r.pop_valid = 1'b1;
          held_count--;
        end
      end
      REQ_CLEAR: begin
        // words stay in the store but can no longer be reached
        head_slot  = 0;
        tail_slot  = 0;
        held_count = 0;
      end
      default: ;  // codes 5..7: no operation, count reported as is
    endcase
    r.total = TOTAL_W'(held_count);
    return r;
  endfunction

  // -------------------------------------------------------------------------
  // Request side: bursts of random length with random gaps in between.
  // -------------------------------------------------------------------------
  bit gaps_on;
  int burst_left;

  // word to push; extremes come up often so every bit flips both ways
  function automatic logic [FIELD_W-1:0] pick_word();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // Offer one request word, wait for it to be taken, record its result.
  // Unless a burst ends, in_valid stays high on return so the next word can follow back to back.
  task automatic send_request(input logic [REQ_W-1:0] req,
                              input logic [FIELD_W-1:0] word);
    in_valid     <= 1'b1;
    in_req_type  <= req;
    in_item_data <= word;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(apply_request(req, word));
    if (gaps_on) begin
      if (burst_left == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        burst_left = $urandom_range(1, 20);
      end else begin
        burst_left--;
      end
    end
  endtask

  // -------------------------------------------------------------------------
  // Result side: random stall rate, plus one long hold-off on request.
  // -------------------------------------------------------------------------
  int stall_pct;
  bit hold_req;
  int hold_left;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_LEN;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // -------------------------------------------------------------------------
  // Result checker: every accepted result word against the oldest expected.
  // -------------------------------------------------------------------------
  function automatic void check_field(input string name,
                                      input logic [FIELD_W-1:0] want,
                                      input logic [FIELD_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin
    dq_result_t exp_res;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result word with nothing pending, actual pop_data %h",
                 $time, out_pop_data);
        mismatch_count++;
      end else begin
        exp_res = pending_results.pop_front();
        check_field("pop_data",    exp_res.pop_data,  out_pop_data);
        check_field("pop_valid",   FIELD_W'(exp_res.pop_valid),
                    FIELD_W'(out_pop_valid));
        check_field("status",      FIELD_W'(exp_res.status),
                    FIELD_W'(out_status));
        check_field("entry_total", FIELD_W'(exp_res.total),
                    FIELD_W'(out_entry_total));
      end
    end
  end

  // watchdog: a hang shows up as a long run of cycles with no handshake
  int idle_cycles;

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  // -------------------------------------------------------------------------
  // Tests
  // -------------------------------------------------------------------------

  // pops on the empty queue right after reset: both refused with empty status
  task automatic test_empty_pops();
    send_request(REQ_POP_FRONT, '1);
    send_request(REQ_POP_BACK, 32'hA5A5_5A5A);
  endtask

  // fill from both ends up to full, then both pushes must be refused
  task automatic test_full_refusals();
    logic [FIELD_W-1:0] w;
    for (int i = 0; i < DEPTH; i++) begin
      case (i)
        0:       w = '0;
        1:       w = '1;
        2:       w = 32'hAAAA_5555;
        3:       w = 32'h5555_AAAA;
        default: w = $urandom;
      endcase
      send_request(i[0] ? REQ_PUSH_BACK : REQ_PUSH_FRONT, w);
    end
    send_request(REQ_PUSH_FRONT, $urandom);
    send_request(REQ_PUSH_BACK, $urandom);
  endtask

  // pops from both ends, unused codes, clear, and a pop after clear
  task automatic test_misc_codes();
    send_request(REQ_POP_FRONT, $urandom);
    send_request(REQ_POP_BACK, $urandom);
    for (int c = REQ_CLEAR + 1; c < (1 << REQ_W); c++) begin
      send_request(REQ_W'(c), $urandom);
    end
    send_request(REQ_CLEAR, $urandom);
    send_request(REQ_POP_FRONT, $urandom);
  endtask

  // random requests; push_pct steers toward full or empty
  task automatic run_mixed(input int count, input int push_pct);
    int               r;
    logic [REQ_W-1:0] req;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(999);
      if (r < 8) begin
        req = REQ_CLEAR;
      end else if (r < 20) begin
        req = REQ_W'($urandom_range(REQ_CLEAR + 1, (1 << REQ_W) - 1));
      end else if ($urandom_range(99) < push_pct) begin
        req = $urandom_range(1) ? REQ_PUSH_BACK : REQ_PUSH_FRONT;
      end else begin
        req = $urandom_range(1) ? REQ_POP_BACK : REQ_POP_FRONT;
      end
      send_request(req, pick_word());
    end
  endtask

  // swing between full and empty several times to exercise wraparound
  task automatic test_fill_drain();
    gaps_on   = 1'b1;
    stall_pct = 20;
    for (int k = 0; k < 3; k++) begin
      run_mixed(100, 80);
      run_mixed(100, 20);
    end
  endtask

  task automatic test_balanced_with_stalls();
    gaps_on   = 1'b1;
    stall_pct = 40;
    run_mixed(400, 50);
  endtask

  // one word per cycle, no idling on either side
  task automatic test_back_to_back();
    gaps_on   = 1'b0;
    stall_pct = 0;
    run_mixed(250, 60);
    run_mixed(150, 40);
  endtask

  // result side holds off while requests keep coming: queue backs up
  task automatic test_output_hold();
    gaps_on   = 1'b0;
    stall_pct = 0;
    hold_req  = 1'b1;
    run_mixed(60, 55);
  endtask

  task automatic test_random_stress();
    gaps_on   = 1'b1;
    stall_pct = 60;
    run_mixed(200, 50);
    stall_pct = 10;
    run_mixed(170, 65);
    run_mixed(100, 35);
  endtask

  initial begin
    head_slot      = 0;
    tail_slot      = 0;
    held_count     = 0;
    mismatch_count = 0;
    idle_cycles    = 0;
    gaps_on        = 1'b0;
    burst_left     = 0;
    stall_pct      = 0;
    hold_req       = 1'b0;
    hold_left      = 0;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_pops();
    test_full_refusals();
    test_misc_codes();
    test_fill_drain();
    test_balanced_with_stalls();
    test_back_to_back();
    test_output_hold();
    test_random_stress();

    in_valid  <= 1'b0;
    stall_pct = 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

/* sim.f */
src/dq_pkg.sv
src/dq_cell.sv
src/double_ended_queue.sv
verif/tb_top.sv
